[rtl/core/lru_key_value_cache_macros.svh]
// Assertion macros used by the LRU cache checker.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define LKVC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define LKVC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/lkvc_pkg.sv]
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int KEY_BITS_DEFAULT   = 32;
   localparam int VALUE_BITS_DEFAULT = 32;

   localparam int CAP_BITS  = 5;
   localparam int CAP_RESET = 16;

   localparam int OPCODE_BITS = 2;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_PUT   = 2'd0,
      OP_GET   = 2'd1,
      OP_PROBE = 2'd2,
      OP_CLEAR = 2'd3
   } opcode_type;

endpackage

[rtl/core/lru_key_value_cache.sv]
// Fully associative key-value cache with least-recently-used replacement.
//
// One transfer on req_ carries an opcode (put, get, probe, clear), a key and
// a put value; each produces exactly one rsp_ transfer with the hit flag, the
// value read by a get hit, and the occupancy afterwards. The block takes one
// item per clock cycle while rsp_ready does not stall the output register. An
// input register feeds a single pass that compares the key against all DEPTH
// entries in parallel and updates the recency ranks, and the result lands in
// an output register. Each item sees the state that the previous one left.
// csr_write_en writes the capacity register (reset 16); zero acts as one and
// values above DEPTH act as DEPTH. Lowering it below the occupancy keeps the
// entries until the next put that misses.
module lru_key_value_cache #(
   parameter int DEPTH      = lkvc_pkg::DEPTH_DEFAULT,
   parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEFAULT,
   parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEFAULT,
   localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W     = $clog2(DEPTH + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [lkvc_pkg::OPCODE_BITS-1:0] req_opcode,
   input  logic [KEY_BITS-1:0]              req_key,
   input  logic [VALUE_BITS-1:0]            req_write_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_hit,
   output logic [VALUE_BITS-1:0]            rsp_read_value,
   output logic [CNT_W-1:0]                 rsp_occupancy,
   input  logic                             csr_write_en,
   input  logic [lkvc_pkg::CAP_BITS-1:0]    csr_write_data
);

   // Input stage
   logic                       s1_valid_ff;
   lkvc_pkg::opcode_type       s1_opcode_ff;
   logic [KEY_BITS-1:0]        s1_key_ff;
   logic [VALUE_BITS-1:0]      s1_value_ff;

   // Result stage
   logic                       rsp_valid_ff;
   logic                       rsp_hit_ff;
   logic [VALUE_BITS-1:0]      rsp_value_ff;
   logic [CNT_W-1:0]           rsp_count_ff;

   // Cache state
   logic [KEY_BITS-1:0]        key_ff   [DEPTH];
   logic [VALUE_BITS-1:0]      value_ff [DEPTH];
   logic [DEPTH-1:0]           valid_ff;
   logic [IDX_W-1:0]           rank_ff  [DEPTH];
   logic [CNT_W-1:0]           count_ff;
   logic [lkvc_pkg::CAP_BITS-1:0] capacity_ff;

   logic [DEPTH-1:0]           valid_in;
   logic [IDX_W-1:0]           rank_in  [DEPTH];
   logic [CNT_W-1:0]           count_in;
   logic                       write_en;
   logic [IDX_W-1:0]           write_idx;

   logic                       advance;
   logic                       step;
   logic [CNT_W-1:0]           eff_cap;
   logic [DEPTH-1:0]           match;
   logic                       found;
   logic [IDX_W-1:0]           found_idx;
   logic [IDX_W-1:0]           found_rank;
   logic [VALUE_BITS-1:0]      found_value;
   logic [DEPTH-1:0]           kept_valid;
   logic [IDX_W-1:0]           free_idx;
   logic                       hit_in;
   logic [VALUE_BITS-1:0]      read_in;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign step      = s1_valid_ff && advance;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_occupancy  = rsp_count_ff;

   always_comb begin
      if (capacity_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (32'(capacity_ff) > 32'(DEPTH)) begin
         eff_cap = CNT_W'(DEPTH);
      end else begin
         eff_cap = CNT_W'(capacity_ff);
      end
   end

   // Parallel lookup; keys of valid entries are distinct, so match is one-hot or zero.
   always_comb begin
      found_idx   = '0;
      found_rank  = '0;
      found_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == s1_key_ff);
         if (match[i]) begin
            found_idx = IDX_W'(i);
         end
         found_rank  = found_rank  | (match[i] ? rank_ff[i]  : '0);
         found_value = found_value | (match[i] ? value_ff[i] : '0);
      end
      found = |match;
   end

   // Put miss at capacity: drop every entry ranked capacity-1 or older.
   always_comb begin
      free_idx = '0;
      for (int i = 0; i < DEPTH; i++) begin
         kept_valid[i] = valid_ff[i] &&
                         !((count_ff >= eff_cap) &&
                           (CNT_W'(rank_ff[i]) >= eff_cap - CNT_W'(1)));
      end
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (!kept_valid[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      valid_in  = valid_ff;
      rank_in   = rank_ff;
      count_in  = count_ff;
      write_en  = 1'b0;
      write_idx = found_idx;
      hit_in    = 1'b0;
      read_in   = '0;
      case (s1_opcode_ff)
         lkvc_pkg::OP_CLEAR: begin
            valid_in = '0;
            count_in = '0;
         end
         lkvc_pkg::OP_PROBE: begin
            hit_in = found;
         end
         lkvc_pkg::OP_GET, lkvc_pkg::OP_PUT: begin
            hit_in = found;
            if (found) begin
               // Refresh: age everything newer than the hit entry.
               for (int i = 0; i < DEPTH; i++) begin
                  if (valid_ff[i] && (rank_ff[i] < found_rank)) begin
                     rank_in[i] = rank_ff[i] + IDX_W'(1);
                  end
               end
               rank_in[found_idx] = '0;
               if (s1_opcode_ff == lkvc_pkg::OP_GET) begin
                  read_in = found_value;
               end else begin
                  write_en = 1'b1;
               end
            end else if (s1_opcode_ff == lkvc_pkg::OP_PUT) begin
               for (int i = 0; i < DEPTH; i++) begin
                  if (kept_valid[i]) begin
                     rank_in[i] = rank_ff[i] + IDX_W'(1);
                  end
               end
               valid_in           = kept_valid;
               valid_in[free_idx] = 1'b1;
               rank_in[free_idx]  = '0;
               write_en           = 1'b1;
               write_idx          = free_idx;
               count_in = (count_ff >= eff_cap) ? eff_cap : count_ff + CNT_W'(1);
            end
         end
         default: begin
            hit_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
         capacity_ff  <= lkvc_pkg::CAP_BITS'(lkvc_pkg::CAP_RESET);
      end else begin
         if (csr_write_en) begin
            capacity_ff <= csr_write_data;
         end
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (step) begin
            valid_ff <= valid_in;
            count_ff <= count_in;
         end
      end
   end

   // Payload: no reset needed.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_opcode_ff <= lkvc_pkg::opcode_type'(req_opcode);
         s1_key_ff    <= req_key;
         s1_value_ff  <= req_write_value;
      end
      if (step) begin
         rsp_hit_ff   <= hit_in;
         rsp_value_ff <= read_in;
         rsp_count_ff <= count_in;
         rank_ff      <= rank_in;
         if (write_en) begin
            key_ff[write_idx]   <= s1_key_ff;
            value_ff[write_idx] <= s1_value_ff;
         end
      end
   end

endmodule

[rtl/core/lkvc_checker.sv]
// Port-level assertions for the LRU key-value cache, bound to the top level.
`include "lru_key_value_cache_macros.svh"

module lkvc_checker #(
   parameter int DEPTH      = lkvc_pkg::DEPTH_DEFAULT,
   parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEFAULT,
   localparam int CNT_W     = $clog2(DEPTH + 1)
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_hit,
   input logic [VALUE_BITS-1:0] rsp_read_value,
   input logic [CNT_W-1:0]      rsp_occupancy
);

   `LKVC_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, reset |=> !rsp_valid, "result valid after reset")

   `LKVC_ASSERT(a_occ_bound, clock, reset, rsp_valid |-> (32'(rsp_occupancy) <= 32'(DEPTH)), "occupancy exceeds depth")

   `LKVC_ASSERT(a_value_needs_hit, clock, reset, (rsp_valid && (rsp_read_value != '0)) |-> rsp_hit, "read value without a hit")

   `LKVC_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_hit) && $stable(rsp_read_value) && $stable(rsp_occupancy)), "stalled result changed")

endmodule

bind lru_key_value_cache lkvc_checker #(
   .DEPTH      (DEPTH),
   .VALUE_BITS (VALUE_BITS)
) u_lkvc_checker (.*);
